### rtl/core/sbt_pkg.sv
package sbt_pkg;

    localparam int SBT_CAPACITY = 32;
    localparam int SBT_VAL_W    = 8;
    localparam int SBT_OP_W     = 3;
    localparam int SBT_ST_W     = 3;
    localparam int SBT_COUNT_W  = 6;

    typedef logic signed [SBT_VAL_W-1:0] t_val;

    localparam logic [SBT_OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [SBT_OP_W-1:0] OP_SEARCH = 3'd1;
    localparam logic [SBT_OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [SBT_OP_W-1:0] OP_SHOW   = 3'd3;
    localparam logic [SBT_OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [SBT_ST_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [SBT_ST_W-1:0] ST_FOUND    = 3'd1;
    localparam logic [SBT_ST_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [SBT_ST_W-1:0] ST_REMOVED  = 3'd3;
    localparam logic [SBT_ST_W-1:0] ST_ABSENT   = 3'd4;
    localparam logic [SBT_ST_W-1:0] ST_FULL     = 3'd5;
    localparam logic [SBT_ST_W-1:0] ST_EMPTY    = 3'd6;
    localparam logic [SBT_ST_W-1:0] ST_READOUT  = 3'd7;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_DELETE,
        CMD_ROTATE,
        CMD_DRAIN
    } t_cmd;

    typedef struct packed {
        logic vld;
        t_val val;
        logic lt;
    } t_link;

    typedef struct packed {
        logic found;
        t_val head;
    } t_chain_stat;

    localparam t_link LINK_LEFT_END  = '{vld: 1'b1, val: '0, lt: 1'b1};
    localparam t_link LINK_RIGHT_END = '{vld: 1'b0, val: '0, lt: 1'b0};

endpackage

### rtl/core/sbt_in_if.sv
interface sbt_in_if
    import sbt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SBT_OP_W-1:0] op;
    t_val                item_value;

    modport source (output valid, output op, output item_value, input ready);
    modport sink (input valid, input op, input item_value, output ready);
endinterface

### rtl/core/sbt_out_if.sv
interface sbt_out_if
    import sbt_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [SBT_ST_W-1:0]    status;
    t_val                   entry_value;
    logic                   last_of_run;
    logic [SBT_COUNT_W-1:0] entry_count;

    modport source (
        output valid, output status, output entry_value, output last_of_run,
        output entry_count, input ready
    );
    modport sink (
        input valid, input status, input entry_value, input last_of_run,
        input entry_count, output ready
    );
endinterface

### rtl/core/sbt_cell.sv
module sbt_cell
    import sbt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_val  i_key,
    input  t_val  i_head,
    input  t_link i_left,
    input  t_link i_right,
    output t_link o_link,
    output logic  o_eq
);

    logic r_vld;
    t_val r_val;
    logic n_vld;
    t_val n_val;
    logic w_lt;

    assign w_lt   = r_vld && (r_val < i_key);
    assign o_eq   = r_vld && (r_val == i_key);
    assign o_link = '{vld: r_vld, val: r_val, lt: w_lt};

    always_comb begin
        n_vld = r_vld;
        n_val = r_val;
        unique case (i_cmd)
            CMD_INSERT: begin
                if (!w_lt) begin
                    if (i_left.lt) begin
                        n_vld = 1'b1;
                        n_val = i_key;
                    end else begin
                        n_vld = i_left.vld;
                        n_val = i_left.val;
                    end
                end
            end
            CMD_DELETE: begin
                if (!w_lt) begin
                    n_vld = i_right.vld;
                    n_val = i_right.val;
                end
            end
            CMD_ROTATE: begin
                if (r_vld) begin
                    n_val = i_right.vld ? i_right.val : i_head;
                end
            end
            CMD_DRAIN: begin
                n_vld = i_right.vld;
                n_val = i_right.val;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

### rtl/core/sbt_chain.sv
module sbt_chain
    import sbt_pkg::*;
#(
    parameter int CAPACITY = SBT_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_val        i_key,
    output t_chain_stat o_stat
);

    t_link               w_link [CAPACITY];
    logic [CAPACITY-1:0] w_eq;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_link w_left;
        t_link w_right;

        if (g == 0) begin : g_first
            assign w_left = LINK_LEFT_END;
        end else begin : g_mid_l
            assign w_left = w_link[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = LINK_RIGHT_END;
        end else begin : g_mid_r
            assign w_right = w_link[g+1];
        end

        sbt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (i_cmd),
            .i_key   (i_key),
            .i_head  (w_link[0].val),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[g]),
            .o_eq    (w_eq[g])
        );
    end

    assign o_stat = '{found: |w_eq, head: w_link[0].val};

endmodule

### rtl/core/sorted_byte_table.sv
// channel  dir  fields                                            handshake
// i_in     in   op, item_value                                    valid / ready
// o_out    out  status, entry_value, last_of_run, entry_count     valid / ready
//
// insert, search and delete: the cell row compares all entries against the key at once
// and shifts at the same edge that accepts the item
// show and clear emit one entry per cycle while the output register is free, by rotating
// or draining the cell row; on an empty row they emit a single ST_EMPTY item
// reset (synchronous, active low) empties the row and the output register
// the output register holds an item until taken; a new item enters once it is free
module sorted_byte_table
    import sbt_pkg::*;
#(
    parameter int CAPACITY = SBT_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sbt_in_if.sink    i_in,
    sbt_out_if.source o_out
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_STREAM
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [CW-1:0]       r_left;
    logic [CW-1:0]       n_left;
    logic                r_clr;
    logic                n_clr;
    logic                r_ovld;
    logic                n_ovld;
    logic [SBT_ST_W-1:0] r_status;
    logic [SBT_ST_W-1:0] n_status;
    t_val                r_value;
    t_val                n_value;
    logic                r_last;
    logic                n_last;
    logic [CW-1:0]       r_ecount;
    logic [CW-1:0]       n_ecount;

    t_cmd        w_cmd;
    t_chain_stat w_stat;
    logic        w_free;
    logic        w_acc;
    logic        w_full;

    assign w_free      = !r_ovld || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && w_free;
    assign w_acc       = i_in.valid && i_in.ready;
    assign w_full      = (r_count == CW'(CAPACITY));

    assign o_out.valid       = r_ovld;
    assign o_out.status      = r_status;
    assign o_out.entry_value = r_value;
    assign o_out.last_of_run = r_last;
    assign o_out.entry_count = SBT_COUNT_W'(r_ecount);

    sbt_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_key   (i_in.item_value),
        .o_stat  (w_stat)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_left   = r_left;
        n_clr    = r_clr;
        n_ovld   = r_ovld && !o_out.ready;
        n_status = r_status;
        n_value  = r_value;
        n_last   = r_last;
        n_ecount = r_ecount;
        w_cmd    = CMD_HOLD;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_value = '0;
                    n_last  = 1'b1;
                    case (i_in.op) inside
                        OP_INSERT: begin
                            n_ovld = 1'b1;
                            if (w_full) begin
                                n_status = ST_FULL;
                                n_ecount = r_count;
                            end else begin
                                w_cmd    = CMD_INSERT;
                                n_count  = r_count + 1'b1;
                                n_status = ST_INSERTED;
                                n_ecount = r_count + 1'b1;
                            end
                        end
                        OP_SEARCH: begin
                            n_ovld   = 1'b1;
                            n_status = w_stat.found ? ST_FOUND : ST_NOTFOUND;
                            n_ecount = r_count;
                        end
                        OP_DELETE: begin
                            n_ovld = 1'b1;
                            if (w_stat.found) begin
                                w_cmd    = CMD_DELETE;
                                n_count  = r_count - 1'b1;
                                n_status = ST_REMOVED;
                                n_ecount = r_count - 1'b1;
                            end else begin
                                n_status = ST_ABSENT;
                                n_ecount = r_count;
                            end
                        end
                        OP_SHOW, OP_CLEAR: begin
                            if (r_count == '0) begin
                                n_ovld   = 1'b1;
                                n_status = ST_EMPTY;
                                n_ecount = '0;
                            end else begin
                                n_state = S_STREAM;
                                n_left  = r_count;
                                n_clr   = (i_in.op == OP_CLEAR);
                                if (i_in.op == OP_CLEAR) begin
                                    n_count = '0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_STREAM: begin
                if (w_free) begin
                    w_cmd    = r_clr ? CMD_DRAIN : CMD_ROTATE;
                    n_ovld   = 1'b1;
                    n_status = ST_READOUT;
                    n_value  = w_stat.head;
                    n_last   = (r_left == CW'(1));
                    n_ecount = r_count;
                    n_left   = r_left - 1'b1;
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_left  <= '0;
            r_clr   <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            r_clr   <= n_clr;
            r_ovld  <= n_ovld;
        end
        r_status <= n_status;
        r_value  <= n_value;
        r_last   <= n_last;
        r_ecount <= n_ecount;
    end

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STREAM) |-> (r_left != '0))
        else $error("stream state with no entries left");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_in.op == OP_INSERT) && !w_full) |=>
            (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the count");

    a_run_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !r_last) |-> (r_state == S_STREAM))
        else $error("open readout run outside stream state");

endmodule

### bench/tb_sorted_byte_table.sv
module tb_sorted_byte_table
    import sbt_pkg::*;
;
    localparam logic [SBT_OP_W-1:0] OP_UNDEF_LO = 3'd5;
    localparam logic [SBT_OP_W-1:0] OP_UNDEF_HI = 3'd7;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 2 * SBT_CAPACITY + 8;

    typedef struct packed {
        logic [SBT_ST_W-1:0]    status;
        t_val                   entry_value;
        logic                   last_of_run;
        logic [SBT_COUNT_W-1:0] entry_count;
    } t_reply;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sbt_in_if  in_ch ();
    sbt_out_if out_ch ();

    sorted_byte_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_val   model_entries[$];
    t_reply pending_replies[$];
    int     mismatch_count = 0;
    int     tx_idle_pct = 0;
    int     rx_idle_pct = 0;
    int     rx_hold_left = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void add_reply(logic [SBT_ST_W-1:0] status, t_val value, logic last,
                                      int count);
        t_reply r;
        r.status      = status;
        r.entry_value = value;
        r.last_of_run = last;
        r.entry_count = SBT_COUNT_W'(count);
        pending_replies.push_back(r);
    endfunction

    function automatic void add_readout(int count_after);
        if (model_entries.size() == 0) begin
            add_reply(ST_EMPTY, '0, 1'b1, count_after);
        end else begin
            foreach (model_entries[i])
                add_reply(ST_READOUT, model_entries[i], i == model_entries.size() - 1,
                          count_after);
        end
    endfunction

    function automatic void predict_table_op(logic [SBT_OP_W-1:0] op, t_val value);
        int pos;
        int hit;
        pos = 0;
        hit = -1;
        case (op) inside
            OP_INSERT: begin
                if (model_entries.size() >= SBT_CAPACITY) begin
                    add_reply(ST_FULL, '0, 1'b1, model_entries.size());
                end else begin
                    while (pos < model_entries.size() && model_entries[pos] < value)
                        pos++;
                    model_entries.insert(pos, value);
                    add_reply(ST_INSERTED, '0, 1'b1, model_entries.size());
                end
            end
            OP_SEARCH, OP_DELETE: begin
                foreach (model_entries[i])
                    if (hit < 0 && model_entries[i] == value)
                        hit = i;
                if (op == OP_SEARCH) begin
                    add_reply(hit >= 0 ? ST_FOUND : ST_NOTFOUND, '0, 1'b1,
                              model_entries.size());
                end else if (hit >= 0) begin
                    model_entries.delete(hit);
                    add_reply(ST_REMOVED, '0, 1'b1, model_entries.size());
                end else begin
                    add_reply(ST_ABSENT, '0, 1'b1, model_entries.size());
                end
            end
            OP_SHOW: add_readout(model_entries.size());
            OP_CLEAR: begin
                add_readout(0);
                model_entries.delete();
            end
            default: ;
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic send_item(logic [SBT_OP_W-1:0] op, t_val value);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.op         <= op;
        in_ch.item_value <= value;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_table_op(op, value);
        @(negedge i_clk);
    endtask

    function automatic t_val pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 40 && model_entries.size() > 0)
            return model_entries[$urandom_range(model_entries.size() - 1)];
        if (r < 55) begin
            case ($urandom_range(3))
                0: return t_val'(-128);
                1: return t_val'(127);
                2: return t_val'(0);
                default: return t_val'(-1);
            endcase
        end
        return t_val'($urandom_range(255));
    endfunction

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic test_empty_store();
        send_item(OP_SHOW, t_val'(5));
        send_item(OP_CLEAR, t_val'(-5));
        send_item(OP_SEARCH, t_val'(0));
        send_item(OP_DELETE, t_val'(0));
        for (int c = OP_UNDEF_LO; c <= OP_UNDEF_HI; c++)
            send_item(SBT_OP_W'(c), t_val'($urandom_range(255)));
    endtask

    task automatic test_order_and_duplicates();
        send_item(OP_INSERT, t_val'(127));
        send_item(OP_INSERT, t_val'(-128));
        send_item(OP_INSERT, t_val'(0));
        send_item(OP_INSERT, t_val'(-1));
        send_item(OP_INSERT, t_val'(127));
        send_item(OP_INSERT, t_val'(0));
        send_item(OP_SEARCH, t_val'(-128));
        send_item(OP_SEARCH, t_val'(127));
        send_item(OP_SEARCH, t_val'(1));
        send_item(OP_DELETE, t_val'(0));
        send_item(OP_DELETE, t_val'(55));
        send_item(OP_SHOW, t_val'(0));
        send_item(OP_CLEAR, t_val'(0));
        send_item(OP_SHOW, t_val'(0));
    endtask

    task automatic test_random_mix(int n_items);
        int done_items;
        int r;
        done_items = 0;
        while (done_items < n_items) begin
            r = $urandom_range(99);
            if (r < 45) begin
                send_item(OP_INSERT, pick_value());
            end else if (r < 60) begin
                send_item(OP_SEARCH, pick_value());
            end else if (r < 80) begin
                send_item(OP_DELETE, pick_value());
            end else if (r < 88) begin
                send_item(OP_SHOW, pick_value());
            end else if (r < 92) begin
                send_item(OP_CLEAR, pick_value());
            end else if (r < 95) begin
                send_item(SBT_OP_W'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO)), pick_value());
                done_items--;
            end else begin
                send_item(OP_INSERT, pick_value());
            end
            done_items++;
        end
    endtask

    task automatic test_fill_to_capacity();
        while (model_entries.size() < SBT_CAPACITY)
            send_item(OP_INSERT, pick_value());
        send_item(OP_INSERT, t_val'(-128));
        send_item(OP_INSERT, t_val'(127));
        send_item(OP_SEARCH, pick_value());
        send_item(OP_SHOW, t_val'(0));
        send_item(OP_DELETE, pick_value());
        send_item(OP_INSERT, pick_value());
        send_item(OP_INSERT, pick_value());
        send_item(OP_CLEAR, t_val'(0));
    endtask

    task automatic test_output_backpressure();
        repeat (12)
            send_item(OP_INSERT, pick_value());
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        rx_hold_left = RX_HOLD_CYCLES;
        @(negedge i_clk);
        send_item(OP_SHOW, t_val'(0));
        send_item(OP_SEARCH, pick_value());
        send_item(OP_INSERT, pick_value());
        send_item(OP_DELETE, pick_value());
        send_item(OP_SHOW, t_val'(0));
        send_item(OP_CLEAR, t_val'(0));
        send_item(OP_SHOW, t_val'(0));
        send_item(OP_INSERT, pick_value());
    endtask

    // receiver side
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                out_ch.ready <= 1'b0;
                rx_hold_left = rx_hold_left - 1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : reply_check
        t_reply got;
        t_reply want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.status      = out_ch.status;
            got.entry_value = out_ch.entry_value;
            got.last_of_run = out_ch.last_of_run;
            got.entry_count = out_ch.entry_count;
            if (pending_replies.size() == 0) begin
                $error("unexpected item: status %0d entry_value %0d", got.status,
                       got.entry_value);
                mismatch_count++;
            end else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatch_count++;
                end
                if (got.entry_value !== want.entry_value) begin
                    $error("entry_value: expected %0d, got %0d", want.entry_value,
                           got.entry_value);
                    mismatch_count++;
                end
                if (got.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                           got.last_of_run);
                    mismatch_count++;
                end
                if (got.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count,
                           got.entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.op         = OP_INSERT;
        in_ch.item_value = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        tx_idle_pct = 38;
        rx_idle_pct = 84;
        test_empty_store();
        test_order_and_duplicates();
        test_random_mix(100);

        tx_idle_pct = 84;
        rx_idle_pct = 38;
        test_random_mix(100);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_fill_to_capacity();
        test_output_backpressure();
        test_random_mix(90);

        wait_idle();
        if (mismatch_count == 0) begin
            $display("tb_sorted_byte_table passed");
        end else begin
            $display("tb_sorted_byte_table failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("tb_sorted_byte_table failed");
        $finish;
    end

endmodule
